// File: src/dlm_pkg.sv
// ----------------------------------------------------------------------------
// dlm_pkg: shared types and constants
// Transaction structs, cell control word, sequencer states and the base 10^4
// digit arithmetic constants of the decimal limb multiplier.
// ----------------------------------------------------------------------------
`default_nettype none

package dlm_pkg;

    localparam int DEF_MAX_LIMBS = 16;

    localparam int LIMB_W        = 54;
    localparam int DIG_W         = 14;   // one base 10^4 digit
    localparam int DIGS_PER_LIMB = 4;
    localparam int PROD_W        = 27;   // digit product plus addends, < 10^8
    localparam int CONV_STEPS    = LIMB_W / 2;
    localparam int RECIP_SHIFT   = 40;

    localparam logic [LIMB_W-1:0] LIMB_BASE = 54'd10000000000000000;
    localparam logic [DIG_W-1:0]  DIG_BASE  = 14'd10000;
    // ceil(2^40 / 10^4): exact quotient for every value below 10^8
    localparam logic [PROD_W-1:0] DIG_RECIP = 27'd109951163;

    localparam logic OP_LEFT  = 1'b0;
    localparam logic OP_RIGHT = 1'b1;

    typedef struct packed {
        logic              opcode;
        logic [LIMB_W-1:0] limb_value;
        logic              is_last;
    } t_in_item;

    typedef struct packed {
        logic [LIMB_W-1:0] product_limb;
        logic              last_limb;
    } t_out_item;

    typedef struct packed {
        logic clear;
        logic shift_a;
        logic shift_rd_up;
        logic shift_rd_down;
        logic ph0;
        logic ph1;
        logic ph2;
    } t_cell_ctl;

    typedef enum logic [3:0] {
        S_IDLE,
        S_CONV,
        S_LOAD,
        S_MUL,
        S_DRAIN,
        S_RD,
        S_LD,
        S_OUT,
        S_CLR
    } t_state;

endpackage

`default_nettype wire

// File: src/dlm_ram.sv
// ----------------------------------------------------------------------------
// dlm_ram: generic single write, single read RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module dlm_ram #(
    parameter int W = 8,
    parameter int D = 2
) (
    input  logic                 i_clk,
    input  logic                 i_we,
    input  logic [$clog2(D)-1:0] i_waddr,
    input  logic [W-1:0]         i_wdata,
    input  logic [$clog2(D)-1:0] i_raddr,
    output logic [W-1:0]         o_rdata
);

    logic [W-1:0] r_mem [D];
    logic [W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

// File: src/dlm_conv.sv
// ----------------------------------------------------------------------------
// dlm_conv: binary limb to base 10^4 digits
// Clamps the limb below 10^16, then shifts it in two bits a cycle into four
// base 10^4 digits (doubling with decimal carry). Digits leave MS first.
// ----------------------------------------------------------------------------
`default_nettype none

module dlm_conv (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic [dlm_pkg::LIMB_W-1:0]  i_value,
    input  logic                        i_pop,
    output logic                        o_busy,
    output logic [dlm_pkg::DIG_W-1:0]   o_digit
);

    import dlm_pkg::*;

    localparam int CW = $clog2(CONV_STEPS + 1);

    logic [LIMB_W-1:0] r_v;
    logic [DIG_W-1:0]  r_d [DIGS_PER_LIMB];
    logic [DIG_W-1:0]  n_d [DIGS_PER_LIMB];
    logic [CW-1:0]     r_cnt;
    logic [15:0]       x;
    logic [1:0]        c;

    // two new bits enter digit 0, carries ripple up through the four digits
    always_comb begin
        c = r_v[LIMB_W-1 -: 2];
        x = '0;
        for (int k = 0; k < DIGS_PER_LIMB; k++) begin
            x = {r_d[k], 2'b00} + 16'(c);
            if (x >= 16'd30000) begin
                c = 2'd3;
                x = x - 16'd30000;
            end else if (x >= 16'd20000) begin
                c = 2'd2;
                x = x - 16'd20000;
            end else if (x >= 16'd10000) begin
                c = 2'd1;
                x = x - 16'd10000;
            end else begin
                c = 2'd0;
            end
            n_d[k] = x[DIG_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_start) begin
            r_cnt <= CW'(CONV_STEPS);
        end else if (r_cnt != '0) begin
            r_cnt <= r_cnt - CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_v <= (i_value >= LIMB_BASE) ? LIMB_BASE - LIMB_W'(1) : i_value;
            for (int k = 0; k < DIGS_PER_LIMB; k++) begin
                r_d[k] <= '0;
            end
        end else if (r_cnt != '0) begin
            r_v <= {r_v[LIMB_W-3:0], 2'b00};
            r_d <= n_d;
        end else if (i_pop) begin
            for (int k = DIGS_PER_LIMB - 1; k > 0; k--) begin
                r_d[k] <= r_d[k-1];
            end
            r_d[0] <= '0;
        end
    end

    assign o_busy  = (r_cnt != '0);
    assign o_digit = r_d[DIGS_PER_LIMB-1];

endmodule

`default_nettype wire

// File: src/dlm_cell.sv
// ----------------------------------------------------------------------------
// dlm_cell: one digit cell of the serial-parallel multiplier chain
// Holds one left digit, one right digit, one accumulator digit and a carry.
// Step: ph0 multiply, ph1 add and quotient, ph2 remainder and shift down.
// ----------------------------------------------------------------------------
`default_nettype none

module dlm_cell (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  dlm_pkg::t_cell_ctl         i_ctl,
    input  logic [dlm_pkg::DIG_W-1:0]  i_b,
    input  logic [dlm_pkg::DIG_W-1:0]  i_a_lo,
    input  logic [dlm_pkg::DIG_W-1:0]  i_rd_lo,
    input  logic [dlm_pkg::DIG_W-1:0]  i_rd_hi,
    input  logic [dlm_pkg::DIG_W-1:0]  i_r_hi,
    input  logic [dlm_pkg::DIG_W-1:0]  i_c_lo,
    output logic [dlm_pkg::DIG_W-1:0]  o_a,
    output logic [dlm_pkg::DIG_W-1:0]  o_rd,
    output logic [dlm_pkg::DIG_W-1:0]  o_r,
    output logic [dlm_pkg::DIG_W-1:0]  o_c
);

    import dlm_pkg::*;

    logic [DIG_W-1:0]    r_a, r_rd, r_acc, r_c, r_q;
    logic [PROD_W-1:0]   r_p, r_t;
    logic [PROD_W-1:0]   w_t;
    logic [2*PROD_W-1:0] w_qm;
    logic [PROD_W-1:0]   w_rem;

    assign w_t   = PROD_W'(r_acc) + r_p + PROD_W'(i_c_lo);
    assign w_qm  = (2*PROD_W)'(w_t) * (2*PROD_W)'(DIG_RECIP);
    assign w_rem = r_t - PROD_W'(r_q) * PROD_W'(DIG_BASE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_ctl.clear) begin
            r_a   <= '0;
            r_rd  <= '0;
            r_acc <= '0;
            r_c   <= '0;
        end else begin
            if (i_ctl.shift_a) begin
                r_a <= i_a_lo;
            end
            if (i_ctl.shift_rd_up) begin
                r_rd <= i_rd_lo;
            end else if (i_ctl.shift_rd_down) begin
                r_rd <= i_rd_hi;
            end
            if (i_ctl.ph2) begin
                r_acc <= i_r_hi;
                r_c   <= r_q;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.ph0) begin
            r_p <= PROD_W'(r_a) * PROD_W'(i_b);
        end
        if (i_ctl.ph1) begin
            r_t <= w_t;
            r_q <= w_qm[RECIP_SHIFT +: DIG_W];
        end
    end

    assign o_a  = r_a;
    assign o_rd = r_rd;
    assign o_r  = w_rem[DIG_W-1:0];
    assign o_c  = r_c;

endmodule

`default_nettype wire

// File: src/dlm_pack.sv
// ----------------------------------------------------------------------------
// dlm_pack: product digit packer
// Gathers product digits, LS first, into binary limbs and writes each
// finished limb to the product RAM at the next limb address.
// ----------------------------------------------------------------------------
`default_nettype none

module dlm_pack #(
    parameter int AW = 5
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_clear,
    input  logic                        i_vld,
    input  logic [dlm_pkg::DIG_W-1:0]   i_digit,
    output logic                        o_we,
    output logic [AW-1:0]               o_waddr,
    output logic [dlm_pkg::LIMB_W-1:0]  o_wdata
);

    import dlm_pkg::*;

    logic [1:0]        r_k;
    logic [LIMB_W-1:0] r_acc;
    logic [AW-1:0]     r_widx;
    logic [LIMB_W-1:0] w_sum;

    function automatic logic [39:0] pow_of(input logic [1:0] k);
        case (k)
            2'd0:    pow_of = 40'd1;
            2'd1:    pow_of = 40'd10000;
            2'd2:    pow_of = 40'd100000000;
            default: pow_of = 40'd1000000000000;
        endcase
    endfunction

    assign w_sum = r_acc + LIMB_W'(LIMB_W'(i_digit) * LIMB_W'(pow_of(r_k)));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_clear) begin
            r_k    <= '0;
            r_acc  <= '0;
            r_widx <= '0;
        end else if (i_vld) begin
            r_k <= r_k + 2'd1;
            if (r_k == 2'd3) begin
                r_acc  <= '0;
                r_widx <= r_widx + AW'(1);
            end else begin
                r_acc <= w_sum;
            end
        end
    end

    assign o_we    = i_vld && (r_k == 2'd3);
    assign o_waddr = r_widx;
    assign o_wdata = w_sum;

endmodule

`default_nettype wire

// File: src/decimal_limb_schoolbook_multiplier_unit.sv
// ----------------------------------------------------------------------------
// decimal_limb_schoolbook_multiplier_unit: base 10^16 multi-limb multiplier
// Loads left and right operand limbs, multiplies on the last right limb and
// returns every product limb, most significant first.
// ----------------------------------------------------------------------------
//
//  channel | direction | handshake                  | payload
//  --------+-----------+----------------------------+-------------------------
//  in      | to block  | i_in_valid / o_in_stall    | i_in_data  (t_in_item)
//  out     | from block| o_out_valid / i_out_stall  | o_out_data (t_out_item)
//
//  A limb load stalls the input through its 27 two-bit decimal conversion
//  steps, a hand-off and the shift of its four digits into the chain.
//  A multiply runs digit steps over the L left and R right limbs, three
//  phases per digit step in the cells, then reads each product limb
//  through the RAM (read, load, emit). A dropped limb is taken in the idle
//  state and not loaded. A chain clear state ends each operation.
//  Reset is synchronous, active low, and clears counts, cells and the FSM.
//  o_in_stall is high whenever an item is in progress; a stalled output
//  transaction holds the block in the emit state with its payload unchanged.
// ----------------------------------------------------------------------------
`default_nettype none

module decimal_limb_schoolbook_multiplier_unit #(
    parameter int MAX_LIMBS = dlm_pkg::DEF_MAX_LIMBS
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  dlm_pkg::t_in_item   i_in_data,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output dlm_pkg::t_out_item  o_out_data
);

    import dlm_pkg::*;

    localparam int NC     = DIGS_PER_LIMB * MAX_LIMBS;  // cells in the chain
    localparam int DEPTH  = 2 * MAX_LIMBS;              // product limbs
    localparam int AW     = $clog2(DEPTH);
    localparam int CNT_W  = $clog2(MAX_LIMBS + 1);
    localparam int TOT_W  = $clog2(DEPTH + 1);
    localparam int STEP_W = TOT_W + 2;

    // sequencer state
    t_state            r_state, n_state;
    logic [CNT_W-1:0]  r_lcnt, r_rcnt;
    logic              r_target;   // operand being loaded
    logic              r_last;     // final right limb seen
    logic [1:0]        r_ph;       // step phase, or digit count while loading
    logic [STEP_W-1:0] r_step;
    logic [AW-1:0]     r_ridx;

    // product digit tap and output register
    logic [DIG_W-1:0]  r_dig;
    logic              r_dig_vld;
    t_out_item         r_out;
    logic              r_out_vld;

    logic              w_in_acc;
    logic              w_conv_start;
    logic              w_conv_busy;
    logic [DIG_W-1:0]  w_conv_digit;
    logic [TOT_W-1:0]  w_total;
    logic [STEP_W-1:0] w_nsteps;
    t_cell_ctl         w_ctl;

    logic [DIG_W-1:0]  w_a  [NC];
    logic [DIG_W-1:0]  w_rd [NC];
    logic [DIG_W-1:0]  w_r  [NC];
    logic [DIG_W-1:0]  w_c  [NC];

    logic              w_we;
    logic [AW-1:0]     w_waddr;
    logic [LIMB_W-1:0] w_wdata;
    logic [LIMB_W-1:0] w_rdata;

    assign w_in_acc = i_in_valid && (r_state == S_IDLE);
    assign w_total  = TOT_W'(r_lcnt) + TOT_W'(r_rcnt);
    assign w_nsteps = {w_total, 2'b00};

    // a limb is converted only if its operand still has room
    assign w_conv_start = w_in_acc &&
        ((i_in_data.opcode == OP_LEFT)  ? (r_lcnt < CNT_W'(MAX_LIMBS))
                                        : (r_rcnt < CNT_W'(MAX_LIMBS)));

    // ---------------- next state ----------------
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (w_conv_start) begin
                    n_state = S_CONV;
                end else if (w_in_acc && i_in_data.opcode == OP_RIGHT &&
                             i_in_data.is_last) begin
                    // full right operand: the dropped last limb still starts
                    n_state = S_MUL;
                end
            end
            S_CONV: begin
                if (!w_conv_busy) begin
                    n_state = S_LOAD;
                end
            end
            S_LOAD: begin
                if (r_ph == 2'd3) begin
                    n_state = (r_target == OP_RIGHT && r_last) ? S_MUL : S_IDLE;
                end
            end
            S_MUL: begin
                if (r_ph == 2'd2 && r_step == w_nsteps - STEP_W'(1)) begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: n_state = S_RD;
            S_RD:    n_state = S_LD;
            S_LD:    n_state = S_OUT;
            S_OUT: begin
                if (!i_out_stall) begin
                    n_state = (r_ridx == '0) ? S_CLR : S_RD;
                end
            end
            S_CLR:   n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // ---------------- cell control ----------------
    always_comb begin
        w_ctl               = '0;
        w_ctl.clear         = (r_state == S_CLR);
        w_ctl.shift_a       = (r_state == S_LOAD) && (r_target == OP_LEFT);
        w_ctl.shift_rd_up   = (r_state == S_LOAD) && (r_target == OP_RIGHT);
        w_ctl.ph0           = (r_state == S_MUL) && (r_ph == 2'd0);
        w_ctl.ph1           = (r_state == S_MUL) && (r_ph == 2'd1);
        w_ctl.ph2           = (r_state == S_MUL) && (r_ph == 2'd2);
        w_ctl.shift_rd_down = w_ctl.ph2;
    end

    // ---------------- control registers ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_lcnt    <= '0;
            r_rcnt    <= '0;
            r_target  <= OP_LEFT;
            r_last    <= 1'b0;
            r_ph      <= '0;
            r_step    <= '0;
            r_ridx    <= '0;
            r_dig_vld <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_dig_vld <= w_ctl.ph2;
            unique case (r_state)
                S_IDLE: begin
                    r_ph   <= '0;
                    r_step <= '0;
                    if (w_in_acc) begin
                        r_target <= i_in_data.opcode;
                        r_last   <= i_in_data.is_last;
                    end
                end
                S_LOAD: begin
                    r_ph <= r_ph + 2'd1;
                    if (r_ph == 2'd3) begin
                        if (r_target == OP_LEFT) begin
                            r_lcnt <= r_lcnt + CNT_W'(1);
                        end else begin
                            r_rcnt <= r_rcnt + CNT_W'(1);
                        end
                    end
                end
                S_MUL: begin
                    if (r_ph == 2'd2) begin
                        r_ph   <= '0;
                        r_step <= r_step + STEP_W'(1);
                    end else begin
                        r_ph <= r_ph + 2'd1;
                    end
                end
                S_DRAIN: begin
                    r_ridx <= AW'(w_total - TOT_W'(1));
                end
                S_LD: begin
                    r_out_vld <= 1'b1;
                end
                S_OUT: begin
                    if (!i_out_stall) begin
                        r_out_vld <= 1'b0;
                        r_ridx    <= r_ridx - AW'(1);
                    end
                end
                S_CLR: begin
                    r_lcnt <= '0;
                    r_rcnt <= '0;
                end
                default: begin
                end
            endcase
        end
    end

    // ---------------- payload registers ----------------
    always_ff @(posedge i_clk) begin
        r_dig <= w_r[0];
        if (r_state == S_LD) begin
            r_out.product_limb <= w_rdata;
            r_out.last_limb    <= (r_ridx == '0);
        end
    end

    // ---------------- datapath ----------------
    dlm_conv u_conv (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_conv_start),
        .i_value (i_in_data.limb_value),
        .i_pop   (r_state == S_LOAD),
        .o_busy  (w_conv_busy),
        .o_digit (w_conv_digit)
    );

    // cell 0 is the least significant digit; loads enter there and shift up,
    // during a multiply right digits and accumulators shift down.
    // The accumulator moves down one cell per step, so a cell's own carry
    // already sits at the next digit position and stays in that cell.
    for (genvar gi = 0; gi < NC; gi++) begin : g_cell
        logic [DIG_W-1:0] a_lo, rd_lo, rd_hi, r_hi;

        if (gi == 0) begin : g_bot
            assign a_lo  = w_conv_digit;
            assign rd_lo = w_conv_digit;
        end else begin : g_mid
            assign a_lo  = w_a[gi-1];
            assign rd_lo = w_rd[gi-1];
        end

        if (gi == NC - 1) begin : g_top
            assign rd_hi = '0;
            assign r_hi  = '0;
        end else begin : g_below
            assign rd_hi = w_rd[gi+1];
            assign r_hi  = w_r[gi+1];
        end

        dlm_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_ctl   (w_ctl),
            .i_b     (w_rd[0]),
            .i_a_lo  (a_lo),
            .i_rd_lo (rd_lo),
            .i_rd_hi (rd_hi),
            .i_r_hi  (r_hi),
            .i_c_lo  (w_c[gi]),
            .o_a     (w_a[gi]),
            .o_rd    (w_rd[gi]),
            .o_r     (w_r[gi]),
            .o_c     (w_c[gi])
        );
    end

    dlm_pack #(
        .AW (AW)
    ) u_pack (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_clear (r_state == S_CLR),
        .i_vld   (r_dig_vld),
        .i_digit (r_dig),
        .o_we    (w_we),
        .o_waddr (w_waddr),
        .o_wdata (w_wdata)
    );

    dlm_ram #(
        .W (LIMB_W),
        .D (DEPTH)
    ) u_prod_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (r_ridx),
        .o_rdata (w_rdata)
    );

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_vld;
    assign o_out_data  = r_out;

endmodule

`default_nettype wire

// File: bench/tb_decimal_limb_schoolbook_multiplier_unit.sv
// ----------------------------------------------------------------------------
// tb_decimal_limb_schoolbook_multiplier_unit: self-checking bench
// Drives left/right limb loads, predicts every product limb with a local
// base 10^16 schoolbook multiply and checks each output transaction in order.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_decimal_limb_schoolbook_multiplier_unit;
    timeunit 1ns;
    timeprecision 1ps;

    import dlm_pkg::*;

    localparam int NUM_LIMBS    = DEF_MAX_LIMBS;
    localparam int IDLE_LIMIT   = 20000;    // cycles with no transaction at all
    localparam logic [LIMB_W-1:0] MAX_DIGIT = LIMB_BASE - 1;

    logic      clk;
    logic      rst_n;
    logic      in_valid;
    logic      in_stall;
    t_in_item  in_data;
    logic      out_valid;
    logic      out_stall;
    t_out_item out_data;

    // idle rates in percent, changed per phase
    int unsigned send_gap_pct;
    int unsigned recv_stall_pct;

    // operand limbs collected for the current operation, MS limb first
    logic [LIMB_W-1:0] left_operand[NUM_LIMBS];
    logic [LIMB_W-1:0] right_operand[NUM_LIMBS];
    int unsigned       left_len;
    int unsigned       right_len;

    t_out_item   pending_limbs[$];
    int unsigned mismatch_count;
    int unsigned idle_cycles;

    decimal_limb_schoolbook_multiplier_unit u_dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_data  (out_data)
    );

    initial begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    task automatic report_mismatch(input string what);
        mismatch_count++;
        $display("ERROR @%0t: %s", $realtime, what);
    endtask

    // Full schoolbook product: exact 128-bit limb product, then split by 10^16.
    // Queues every product limb, MS first, the final one flagged.
    task automatic predict_product();
        logic [LIMB_W-1:0] acc[2*NUM_LIMBS];
        logic [127:0]      wide;
        logic [63:0]       carry;
        logic [63:0]       sum;
        int                total;
        int                k;
        t_out_item         limb;
        total = left_len + right_len;
        for (int i = 0; i < 2*NUM_LIMBS; i++) acc[i] = '0;
        for (int r = 0; r < int'(right_len); r++) begin
            carry = 0;
            k = total - 1 - r;
            for (int j = int'(left_len) - 1; j >= 0; j--) begin
                wide = 128'(left_operand[j]) * 128'(right_operand[right_len-1-r]) + carry;
                carry = 64'(wide / 128'(LIMB_BASE));
                sum = 64'(acc[k]) + 64'(wide % 128'(LIMB_BASE));
                if (sum >= 64'(LIMB_BASE)) begin
                    sum -= 64'(LIMB_BASE);
                    carry++;
                end
                acc[k] = sum[LIMB_W-1:0];
                k--;
            end
            // row carry lands just above the row
            if (carry != 0) acc[k] = carry[LIMB_W-1:0];
        end
        for (int i = 0; i < total; i++) begin
            limb.product_limb = acc[i];
            limb.last_limb    = (i == total - 1);
            pending_limbs.push_back(limb);
        end
        left_len  = 0;
        right_len = 0;
    endtask

    // One input transaction; updates the operand copy on acceptance.
    // Valid stays up after the accepting edge only until the next falling
    // edge, where it either carries the next payload or drops.
    task automatic send_limb(input logic op, input logic [LIMB_W-1:0] value,
                             input logic final_mark);
        logic [LIMB_W-1:0] digit;
        while ($urandom_range(99) < send_gap_pct) begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid           <= 1'b1;
        in_data.opcode     <= op;
        in_data.limb_value <= value;
        in_data.is_last    <= final_mark;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        // accepted at this edge: predict now so results never beat expectations
        digit = (value > MAX_DIGIT) ? MAX_DIGIT : value;    // digit-too-large clamp
        if (op == OP_LEFT) begin
            if (left_len < NUM_LIMBS) left_operand[left_len++] = digit;
        end else begin
            if (right_len < NUM_LIMBS) right_operand[right_len++] = digit;
            if (final_mark) predict_product();
        end
        @(negedge clk);
    endtask

    // random limb: mostly in range, some near the top, some raw 54-bit noise
    function automatic logic [LIMB_W-1:0] random_limb();
        logic [63:0] raw;
        raw = {$urandom, $urandom};
        case ($urandom_range(9))
            0:       return MAX_DIGIT - LIMB_W'($urandom_range(3));
            1:       return raw[LIMB_W-1:0];                    // may exceed a digit
            2:       return LIMB_W'($urandom_range(9));
            default: return LIMB_W'(raw % 64'(LIMB_BASE));
        endcase
    endfunction

    // one well-formed operation with random sizes; small sizes dominate
    task automatic send_operation(input int lcount, input int rcount);
        for (int i = 0; i < lcount; i++)
            send_limb(OP_LEFT, random_limb(), 1'($urandom_range(1)));
        for (int i = 0; i < rcount; i++)
            send_limb(OP_RIGHT, random_limb(), i == rcount - 1);
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        while (pending_limbs.size() != 0) @(negedge clk);
    endtask

    // ---------------- directed tests ----------------
    task automatic test_extremes();
        send_limb(OP_LEFT, MAX_DIGIT, 1'b1);        // left last mark ignored
        send_limb(OP_LEFT, '0, 1'b0);
        send_limb(OP_RIGHT, MAX_DIGIT, 1'b0);
        send_limb(OP_RIGHT, '1, 1'b1);              // clamped, starts multiply
        send_limb(OP_LEFT, '1, 1'b0);
        send_limb(OP_RIGHT, '0, 1'b1);              // zero product
    endtask

    task automatic test_empty_left();
        send_limb(OP_RIGHT, LIMB_W'(12345), 1'b0);
        send_limb(OP_RIGHT, MAX_DIGIT, 1'b1);
    endtask

    task automatic test_full_operands();
        // both sides at capacity, plus dropped extras; the dropped last right
        // limb still starts the multiply
        for (int i = 0; i < NUM_LIMBS + 2; i++) send_limb(OP_LEFT, MAX_DIGIT, 1'b0);
        for (int i = 0; i < NUM_LIMBS + 1; i++)
            send_limb(OP_RIGHT, MAX_DIGIT, i == NUM_LIMBS);
    endtask

    task automatic test_random(input int items);
        int sent;
        int lc;
        int rc;
        sent = 0;
        while (sent < items) begin
            if ($urandom_range(9) == 0) begin
                lc = $urandom_range(NUM_LIMBS + 1);
                rc = $urandom_range(NUM_LIMBS + 1, 1);
            end else begin
                lc = $urandom_range(4);
                rc = $urandom_range(4, 1);
            end
            send_operation(lc, rc);
            sent += lc + rc;
            // hold off now and then until the product has fully drained
            if ($urandom_range(7) == 0) wait_drained();
        end
    endtask

    // ---------------- output side ----------------
    always @(negedge clk) begin
        out_stall <= ($urandom_range(99) < recv_stall_pct);
    end

    always @(posedge clk) begin
        t_out_item want;
        if (rst_n && out_valid && !out_stall) begin
            if (pending_limbs.size() == 0) begin
                report_mismatch($sformatf("unexpected limb %0d", out_data.product_limb));
            end else begin
                want = pending_limbs.pop_front();
                if (out_data.product_limb !== want.product_limb)
                    report_mismatch($sformatf("product_limb %0d, want %0d",
                        out_data.product_limb, want.product_limb));
                if (out_data.last_limb !== want.last_limb)
                    report_mismatch($sformatf("last_limb %0b, want %0b",
                        out_data.last_limb, want.last_limb));
            end
        end
    end

    // watchdog: cycles without any transaction on either channel
    always @(posedge clk) begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("tb_decimal_limb_schoolbook_multiplier_unit failed");
            $finish;
        end
    end

    // ---------------- sequence ----------------
    initial begin
        rst_n          = 1'b0;
        in_valid       = 1'b0;
        in_data        = '0;
        out_stall      = 1'b0;
        send_gap_pct   = 10;
        recv_stall_pct = 49;
        left_len       = 0;
        right_len      = 0;
        mismatch_count = 0;
        idle_cycles    = 0;
        repeat (9) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        test_extremes();
        test_empty_left();
        test_full_operands();
        wait_drained();             // sender holds until everything is back
        test_random(125);

        send_gap_pct   = 49;
        recv_stall_pct = 10;
        test_random(125);

        send_gap_pct   = 0;
        recv_stall_pct = 0;
        test_random(125);

        wait_drained();
        repeat (200) @(negedge clk);

        if (mismatch_count == 0 && pending_limbs.size() == 0)
            $display("tb_decimal_limb_schoolbook_multiplier_unit passed");
        else
            $display("tb_decimal_limb_schoolbook_multiplier_unit failed");
        $finish;
    end

endmodule

`default_nettype wire
